### design/bdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdg_pkg;

	localparam int TEXEL_W = 32;
	localparam int CHAN_W  = 8;
	localparam int NUM_CH  = TEXEL_W / CHAN_W;
	// red, green and blue go through the gamma tables, alpha never does
	localparam int NUM_GAMMA_CH = 3;
	localparam int QUAD_N  = 4;
	localparam int SUM_W   = CHAN_W + 2;

	// gamma 2.2 as the ratio 11/5
	localparam int unsigned GAMMA_NUM = 11;
	localparam int unsigned GAMMA_DEN = 5;
	localparam int unsigned FULL_SCALE = 255;
	localparam int BIG_W = 160;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef chan_t rom_t [2**CHAN_W];

	function automatic logic [BIG_W-1:0] pow_pair(int unsigned a, int unsigned ea,
		int unsigned b, int unsigned eb);
		logic [BIG_W-1:0] r;
		r = BIG_W'(1);
		for (int unsigned i = 0; i < ea; i++) r = r * BIG_W'(a);
		for (int unsigned i = 0; i < eb; i++) r = r * BIG_W'(b);
		return r;
	endfunction

	// 255*(v/255)^(ev/ek) >= k + 1/2, tested exactly as
	// v^ev * 510^ek >= (2k+1)^ek * 255^ev
	function automatic logic reaches(int unsigned v, int unsigned k,
		int unsigned ev, int unsigned ek);
		return pow_pair(v, ev, 2 * FULL_SCALE, ek) >=
			pow_pair(2 * k + 1, ek, FULL_SCALE, ev);
	endfunction

	function automatic rom_t build_rom(int unsigned ev, int unsigned ek);
		rom_t t;
		int unsigned k;
		k = 0;
		for (int unsigned v = 0; v < 2**CHAN_W; v++) begin
			while (k < FULL_SCALE && reaches(v, k, ev, ek)) k++;
			t[v] = CHAN_W'(k);
		end
		return t;
	endfunction

	// sRGB-ish decode (to linear) and encode (back), rounded to nearest
	localparam rom_t LIN_ROM = build_rom(GAMMA_NUM, GAMMA_DEN);
	localparam rom_t ENC_ROM = build_rom(GAMMA_DEN, GAMMA_NUM);

endpackage

`default_nettype wire

### design/bdg_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module bdg_chan import bdg_pkg::*; (
	input  wire chan_t samples [QUAD_N],
	input  wire logic  gamma,
	output chan_t      avg
);

	logic [SUM_W-1:0] sum;
	chan_t            mean;

	always_comb begin
		sum = SUM_W'(2);
		for (int t = 0; t < QUAD_N; t++) begin
			sum = sum + SUM_W'(gamma ? LIN_ROM[samples[t]] : samples[t]);
		end
		mean = sum[SUM_W-1:2];
		avg  = gamma ? ENC_ROM[mean] : mean;
	end

endmodule

`default_nettype wire

### design/box_downsample_2x2_gamma_top.sv
`timescale 1ns / 1ps
`default_nettype none

// 2x2 box downsampler for RGBA8 mip generation. One quad enters per cycle and
// one averaged texel leaves per cycle at full throughput, while m_tready is high;
// the path is the input register, then the gamma lookups and the four-sample
// add, then the result register. Each channel is (s0+s1+s2+s3+2)>>2. With
// srgb_mode set, red, green and blue are decoded through a gamma 2.2 table,
// averaged, and re-encoded; alpha is always averaged as is. Write srgb_mode only
// while no item is in flight; cfg_ready is always high.
module box_downsample_2x2_gamma_top import bdg_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic                    cfg_data,      // srgb_mode
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right
	input  wire logic [QUAD_N*TEXEL_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [TEXEL_W-1:0]           m_tdata        // averaged_texel
);

	logic                        srgb_q;
	logic                        valid_s1;
	logic [QUAD_N*TEXEL_W-1:0]   quad_s1;
	logic                        valid_s2;
	logic [TEXEL_W-1:0]          texel_s2;
	logic                        adv_s1;
	logic                        adv_s2;
	logic [TEXEL_W-1:0]          texel_d;

	assign cfg_ready = 1'b1;
	assign adv_s2    = !valid_s2 || m_tready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign s_tready  = adv_s1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = texel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srgb_q <= 1'b0;
		end else if (cfg_valid) begin
			srgb_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) quad_s1 <= s_tdata;
		if (adv_s2 && valid_s1) texel_s2 <= texel_d;
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
		chan_t samples [QUAD_N];
		chan_t avg;

		for (genvar t = 0; t < QUAD_N; t++) begin : g_tap
			assign samples[t] = quad_s1[t*TEXEL_W + ch*CHAN_W +: CHAN_W];
		end

		bdg_chan u_chan (
			.samples (samples),
			.gamma   (srgb_q && (ch < NUM_GAMMA_CH)),
			.avg     (avg)
		);

		assign texel_d[ch*CHAN_W +: CHAN_W] = avg;
	end

endmodule

`default_nettype wire

### design/bdg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bdg_checker import bdg_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	input  wire logic                      s_tready,
	input  wire logic                      m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic [TEXEL_W-1:0]        m_tdata
);

	// items accepted but not yet delivered; two stages hold at most two
	logic [1:0] inflight_q;
	logic       s_acc;
	logic       m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else if (s_acc && !m_acc) begin
			inflight_q <= inflight_q + 2'd1;
		end else if (m_acc && !s_acc) begin
			inflight_q <= inflight_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 2'd0)
		else $error("result with no item in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more items in flight than stages");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && inflight_q == 2'd0 |=> ##1 m_tvalid)
		else $error("item not delivered after two cycles");

endmodule

bind box_downsample_2x2_gamma_top bdg_checker u_bdg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
